### rtl/fir_filter_q15_rounded_taps_macros.svh
// Assertion macros used by the filter back end (fir_back).
`ifndef FIR_FILTER_Q15_ROUNDED_TAPS_MACROS_SVH
`define FIR_FILTER_Q15_ROUNDED_TAPS_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define FIR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fir assertion failed");
// Next-cycle implication, disabled during reset.
`define FIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fir assertion failed");
`else
`define FIR_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FIR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/fir_pkg.sv
// Shared types and constants of the FIR filter.
`default_nettype none
package fir_pkg;
   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 9;
   localparam int TAP_COUNT_W = 10;
   localparam int ACC_W       = 32;
   localparam int TAPS_DEFAULT = 512;
   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 10'd512;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [ACC_W-1:0] ROUND_BIAS = 32'd64;
   localparam int PROD_SHIFT = 7;
   localparam logic [ACC_W-1:0] OUT_BIAS = 32'd16384;
   localparam int OUT_SHIFT = 15;

   // request kinds carried in req_type
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEFF  = 1'b1;

   typedef struct packed {
      logic                is_coeff;
      logic [INDEX_W-1:0]  index;
      logic [SAMPLE_W-1:0] data;
   } fir_item_type;
endpackage
`default_nettype wire

### rtl/fir_req_if.sv
// Request channel interface: samples and coefficient writes.
`default_nettype none
interface fir_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic signed [fir_pkg::SAMPLE_W-1:0] sample_in;
   logic        [fir_pkg::INDEX_W-1:0]  coeff_index;
   logic signed [fir_pkg::SAMPLE_W-1:0] coeff_value;

   modport source (output valid, req_type, sample_in, coeff_index, coeff_value,
                   input ready);
   modport sink (input valid, req_type, sample_in, coeff_index, coeff_value,
                 output ready);
endinterface
`default_nettype wire

### rtl/fir_rsp_if.sv
// Response channel interface: filtered samples.
`default_nettype none
interface fir_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fir_pkg::SAMPLE_W-1:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink (input valid, sample_out, output ready);
endinterface
`default_nettype wire

### rtl/fir_filter_q15_rounded_taps.sv
// Top level of the direct-form FIR filter with per-product rounding.
`default_nettype none
// Direct-form FIR filter on signed 16-bit samples. A request beat with req_type set
// writes one coefficient (indexes at or above TAPS are dropped) and gives no response;
// a sample beat shifts into the history and gives one response beat. The back end
// runs one multiply-accumulate per tap per cycle, reading the coefficient and history
// memories one entry each cycle over min(tap_count, TAPS) taps, and the response may
// wait for rsp ready; a coefficient write goes into its memory as it leaves the queue.
// A two-entry queue lets the front accept beats while the back end works or a response
// waits. After reset a clearing pass zeroes both memories, and req ready stays low
// meanwhile; the user must write tap_count through csr_wr_en/csr_wr_data only while
// the block is idle, as the block itself does not enforce this.
module fir_filter_q15_rounded_taps #(
   parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   fir_req_if.sink                              req_if,
   fir_rsp_if.source                            rsp_if,
   input  wire logic                            csr_wr_en,
   input  wire logic [fir_pkg::TAP_COUNT_W-1:0] csr_wr_data
);
   logic                  clearing;
   logic                  push_valid;
   logic                  push_ready;
   fir_pkg::fir_item_type push_item;
   logic                  pop_valid;
   logic                  pop_ready;
   fir_pkg::fir_item_type pop_item;

   fir_front #(.TAPS(TAPS)) u_front (
      .req_if     (req_if),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   fir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   fir_back #(.TAPS(TAPS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .clearing    (clearing),
      .rsp_if      (rsp_if)
   );
endmodule
`default_nettype wire

### rtl/fir_front.sv
// Front end: accepts request beats, drops out-of-range coefficient writes, feeds the queue.
`default_nettype none
module fir_front #(
   parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
   fir_req_if.sink               req_if,
   input  wire logic             clearing,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output fir_pkg::fir_item_type push_item
);
   logic is_coeff;
   logic keep;

   assign is_coeff = (req_if.req_type == fir_pkg::REQ_COEFF);
   // drop coefficient writes past the end of the store
   assign keep = !is_coeff || (int'(req_if.coeff_index) < TAPS);

   assign req_if.ready = !clearing && push_ready;
   assign push_valid   = req_if.valid && !clearing && keep;

   assign push_item.is_coeff = is_coeff;
   assign push_item.index    = req_if.coeff_index;
   assign push_item.data     = is_coeff ? req_if.coeff_value : req_if.sample_in;
endmodule
`default_nettype wire

### rtl/fir_queue.sv
// Short FIFO of classified items between front and back end.
`default_nettype none
module fir_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire fir_pkg::fir_item_type push_item,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output fir_pkg::fir_item_type      pop_item
);
   localparam int QD  = fir_pkg::QUEUE_DEPTH;
   localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

   fir_pkg::fir_item_type entry_ff [QD];
   logic [QAW-1:0] wr_ptr_ff;
   logic [QAW-1:0] rd_ptr_ff;
   logic [QAW:0]   count_ff;
   logic           push_fire;
   logic           pop_fire;

   assign push_ready = (count_ff != (QAW+1)'(QD));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= (wr_ptr_ff == QAW'(QD-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == QAW'(QD-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push_fire && pop_fire) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

### rtl/fir_back.sv
// Back end: coefficient and history memories, multiply-accumulate sequencer, result register.
`default_nettype none
`include "fir_filter_q15_rounded_taps_macros.svh"
module fir_back #(
   parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                pop_valid,
   output logic                                     pop_ready,
   input  wire fir_pkg::fir_item_type               pop_item,
   input  wire logic                                csr_wr_en,
   input  wire logic [fir_pkg::TAP_COUNT_W-1:0]     csr_wr_data,
   output logic                                     clearing,
   fir_rsp_if.source                                rsp_if
);
   localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int SW = fir_pkg::SAMPLE_W;
   localparam int CW = fir_pkg::TAP_COUNT_W;
   localparam int AccW = fir_pkg::ACC_W;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RUN, S_DRAIN, S_DONE} state_type;

   state_type state_ff;

   logic [SW-1:0] coef_mem [TAPS];
   logic [SW-1:0] hist_mem [TAPS];

   logic [AW-1:0]   clr_addr_ff;
   logic [AW-1:0]   head_ff;
   logic [AW-1:0]   hist_ra_ff;
   logic [CW-1:0]   k_ff;
   logic [CW-1:0]   n_ff;
   logic [CW-1:0]   tap_count_ff;
   logic            v1_ff;
   logic            v2_ff;
   logic [SW-1:0]   coef_rd_ff;
   logic [SW-1:0]   hist_rd_ff;
   logic [AccW-1:0] prod_ff;
   logic [AccW-1:0] acc_ff;
   logic            out_valid_ff;
   logic [SW-1:0]   out_data_ff;

   logic              pop_fire;
   logic              pop_sample;
   logic              pop_coeff;
   logic [AW-1:0]     head_next;
   logic              issue;
   logic signed [SW-1:0]   coef_s;
   logic signed [SW-1:0]   hist_s;
   logic signed [AccW-1:0] prod_full;
   logic [AccW-1:0]   prod_biased;
   logic [AccW-1:0]   prod_rounded;
   logic [AccW-1:0]   acc_final;

   logic          coef_we;
   logic [AW-1:0] coef_wa;
   logic [SW-1:0] coef_wd;
   logic          hist_we;
   logic [AW-1:0] hist_wa;
   logic [SW-1:0] hist_wd;

   assign clearing   = (state_ff == S_CLEAR);
   assign pop_ready  = (state_ff == S_IDLE);
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_sample = pop_fire && !pop_item.is_coeff;
   assign pop_coeff  = pop_fire && pop_item.is_coeff;
   assign head_next  = (head_ff == AW'(TAPS-1)) ? '0 : head_ff + 1'b1;
   assign issue      = (state_ff == S_RUN) && (k_ff < n_ff);

   assign coef_s       = coef_rd_ff;
   assign hist_s       = hist_rd_ff;
   assign prod_full    = coef_s * hist_s;
   assign prod_biased  = prod_ff + fir_pkg::ROUND_BIAS;
   assign prod_rounded = {{fir_pkg::PROD_SHIFT{prod_biased[AccW-1]}},
                          prod_biased[AccW-1:fir_pkg::PROD_SHIFT]};
   assign acc_final    = acc_ff + fir_pkg::OUT_BIAS;

   // memory write ports: clearing pass zeroes both stores
   always_comb begin
      coef_we = clearing || pop_coeff;
      coef_wa = clearing ? clr_addr_ff : AW'(pop_item.index);
      coef_wd = clearing ? '0 : pop_item.data;
      hist_we = clearing || pop_sample;
      hist_wa = clearing ? clr_addr_ff : head_next;
      hist_wd = clearing ? '0 : pop_item.data;
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= coef_wd;
      end
      coef_rd_ff <= coef_mem[AW'(k_ff)];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[hist_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         head_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         tap_count_ff <= fir_pkg::TAP_COUNT_RESET;
      end else begin
         if (csr_wr_en) begin
            tap_count_ff <= csr_wr_data;
         end
         v1_ff   <= issue;
         v2_ff   <= v1_ff;
         prod_ff <= prod_full;
         if (v2_ff) begin
            acc_ff <= acc_ff + prod_rounded;
         end
         if (out_valid_ff && rsp_if.ready && state_ff != S_DONE) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == AW'(TAPS-1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop_sample) begin
                  head_ff    <= head_next;
                  hist_ra_ff <= head_next;
                  k_ff       <= '0;
                  acc_ff     <= '0;
                  n_ff       <= (int'(tap_count_ff) > TAPS) ? CW'(TAPS) : tap_count_ff;
                  state_ff   <= S_RUN;
               end
            end
            S_RUN: begin
               if (issue) begin
                  k_ff       <= k_ff + 1'b1;
                  hist_ra_ff <= (hist_ra_ff == '0) ? AW'(TAPS-1) : hist_ra_ff - 1'b1;
               end else begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               // wait for the read and multiply stages to empty
               if (!v1_ff && !v2_ff) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!out_valid_ff || rsp_if.ready) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= acc_final[fir_pkg::OUT_SHIFT+SW-1:fir_pkg::OUT_SHIFT];
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.sample_out = out_data_ff;

   `FIR_ASSERT_IMPLIES(a_k_in_range, clock, reset, state_ff == S_RUN, k_ff <= n_ff)
   `FIR_ASSERT_IMPLIES(a_n_bound, clock, reset, state_ff == S_RUN, int'(n_ff) <= TAPS)
   `FIR_ASSERT_IMPLIES(a_done_flushed, clock, reset, state_ff == S_DONE, !v1_ff && !v2_ff)
   `FIR_ASSERT_NEXT(a_issue_in_run, clock, reset, state_ff != S_RUN, !v1_ff)
endmodule
`default_nettype wire
